// ===== rtl/rpkr_pkg.sv =====
// rpkr_pkg: shared types and codes for the range partition key router
package rpkr_pkg;

  localparam int MAX_RESULTS = 64;
  localparam int OP_KINDS    = 8;
  localparam int SEEN_CODES  = 32;

  localparam logic [2:0] CMD_LOAD  = 3'd0;
  localparam logic [2:0] CMD_QUERY = 3'd1;
  localparam logic [2:0] CMD_RDD   = 3'd2;
  localparam logic [2:0] CMD_RDO   = 3'd3;
  localparam logic [2:0] CMD_CLR   = 3'd4;

  localparam logic [2:0] OP_EMPTY   = 3'd0;
  localparam logic [2:0] OP_PRED    = 3'd3;
  localparam logic [2:0] OP_SCAN    = 3'd4;
  localparam logic [2:0] OP_INVALID = 3'd7;

  localparam logic [2:0] KIND_ROUTED = 3'd0;
  localparam logic [2:0] KIND_NOPART = 3'd1;
  localparam logic [2:0] KIND_EMPTY  = 3'd2;
  localparam logic [2:0] KIND_INVAL  = 3'd3;
  localparam logic [2:0] KIND_COUNT  = 3'd4;
  localparam logic [2:0] KIND_ACK    = 3'd5;

  localparam logic CFG_COMM    = 1'b0;
  localparam logic CFG_ENTRIES = 1'b1;

  typedef enum logic [2:0] {
    CLS_LOAD  = 3'd0,
    CLS_QUERY = 3'd1,
    CLS_RDD   = 3'd2,
    CLS_RDO   = 3'd3,
    CLS_CLR   = 3'd4,
    CLS_BAD   = 3'd5
  } cls_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [5:0]         entry_index;
    logic signed [63:0] bound_key;
    logic [4:0]         entry_dest;
    logic [2:0]         op_type;
    logic signed [63:0] query_key;
    logic signed [63:0] right_key;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  dest_id;
    logic [31:0] count_value;
    logic        last;
  } out_t;

  typedef struct packed {
    cls_t               cls;
    logic [5:0]         idx;
    logic signed [63:0] bound;
    logic [4:0]         dest;
    logic [2:0]         op;
    logic signed [63:0] qkey;
    logic signed [63:0] rkey;
  } item_t;

endpackage

// ===== rtl/rpkr_front.sv =====
// rpkr_front: input transfer, command classification and two-entry queue
module rpkr_front import rpkr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  in_t   in_data,
  input  logic  open_i,
  output logic  q_valid,
  output item_t q_item,
  input  logic  q_pop
);

  item_t      q_mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  item_t      cls_item;

  always_comb begin
    cls_item       = '0;
    cls_item.idx   = in_data.entry_index;
    cls_item.bound = in_data.bound_key;
    cls_item.dest  = in_data.entry_dest;
    cls_item.op    = in_data.op_type;
    cls_item.qkey  = in_data.query_key;
    cls_item.rkey  = in_data.right_key;
    unique case (in_data.cmd)
      CMD_LOAD:  cls_item.cls = CLS_LOAD;
      CMD_QUERY: cls_item.cls = CLS_QUERY;
      CMD_RDD:   cls_item.cls = CLS_RDD;
      CMD_RDO:   cls_item.cls = CLS_RDO;
      CMD_CLR:   cls_item.cls = CLS_CLR;
      default:   cls_item.cls = CLS_BAD;
    endcase
  end

  assign in_ready = open_i && (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= cls_item;
    end
  end

endmodule

// ===== rtl/rpkr_back.sv =====
// rpkr_back: table search, scan walk, counters and result register
module rpkr_back import rpkr_pkg::*; #(
  parameter int TABLE_DEPTH = 64,
  parameter int NUM_DESTS   = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_pop,
  input  logic       comm_i,
  input  logic [6:0] entries_i,
  output logic       open_o,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data
);

  localparam int TW = $clog2(TABLE_DEPTH);
  localparam int NW = TW + 1;
  localparam int DW = $clog2(NUM_DESTS);

  typedef enum logic [8:0] {
    S_CLR  = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_SRCH = 9'b000000100,
    S_SCMP = 9'b000001000,
    S_WRD  = 9'b000010000,
    S_WCHK = 9'b000100000,
    S_CWR  = 9'b001000000,
    S_CNT  = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t             state_r, state_nxt;
  logic               open_r, open_nxt;
  logic               ack_r, ack_nxt;
  logic [DW-1:0]      clr_r, clr_nxt;
  logic [NW-1:0]      lo_r, lo_nxt, len_r, len_nxt, p_r, p_nxt;
  logic               first_r, first_nxt, scan_r, scan_nxt, strict_r, strict_nxt;
  logic signed [63:0] key_r, key_nxt, rkey_r, rkey_nxt;
  logic [6:0]         k_r, k_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [4:0]         pend_d_r, pend_d_nxt;
  logic [2:0]         fin_kind_r, fin_kind_nxt;
  logic [31:0]        fin_cnt_r, fin_cnt_nxt;
  logic [DW-1:0]      cnt_addr_r, cnt_addr_nxt;
  logic               cnt_en_r, cnt_en_nxt, cnt_ok_r, cnt_ok_nxt;
  logic [SEEN_CODES-1:0] seen_r, seen_nxt;
  logic [31:0]        opc_r [OP_KINDS];
  logic [31:0]        opc_nxt [OP_KINDS];
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  logic signed [63:0] bnd_mem [TABLE_DEPTH];
  logic [4:0]         dst_mem [TABLE_DEPTH];
  logic [31:0]        cnt_mem [NUM_DESTS];
  logic signed [63:0] bnd_q_r;
  logic [4:0]         dst_q_r;
  logic [31:0]        cnt_q_r;

  logic               t_we, c_we;
  logic [TW-1:0]      t_waddr, t_raddr;
  logic [DW-1:0]      c_waddr, c_raddr;
  logic [31:0]        c_wdata;

  logic [NW-1:0]      n_act, half, mid;
  logic               below, out_free, out_load, walk_go, push_pend;
  logic [2:0]         opc_sel;
  logic [31:0]        opc_rd, cnt_inc;

  always_comb begin
    if ({25'd0, entries_i} > 32'(TABLE_DEPTH)) n_act = NW'(TABLE_DEPTH);
    else n_act = NW'(entries_i);
  end

  assign half     = len_r >> 1;
  assign mid      = lo_r + half;
  assign below    = strict_r ? (bnd_q_r < key_r) : (bnd_q_r <= key_r);
  assign out_free = !out_valid_r || out_ready;
  assign opc_sel  = (q_item.cls == CLS_QUERY) ? q_item.op : q_item.idx[2:0];
  assign opc_rd   = opc_r[opc_sel];
  assign cnt_inc  = (cnt_q_r == 32'hFFFF_FFFF) ? cnt_q_r : cnt_q_r + 32'd1;
  assign walk_go  = first_r || (bnd_q_r <= rkey_r);
  assign push_pend = pend_v_r && (k_r < 7'(MAX_RESULTS));

  always_comb begin
    state_nxt    = state_r;
    open_nxt     = open_r;
    ack_nxt      = ack_r;
    clr_nxt      = clr_r;
    lo_nxt       = lo_r;
    len_nxt      = len_r;
    p_nxt        = p_r;
    first_nxt    = first_r;
    scan_nxt     = scan_r;
    strict_nxt   = strict_r;
    key_nxt      = key_r;
    rkey_nxt     = rkey_r;
    k_nxt        = k_r;
    pend_v_nxt   = pend_v_r;
    pend_d_nxt   = pend_d_r;
    fin_kind_nxt = fin_kind_r;
    fin_cnt_nxt  = fin_cnt_r;
    cnt_addr_nxt = cnt_addr_r;
    cnt_en_nxt   = cnt_en_r;
    cnt_ok_nxt   = cnt_ok_r;
    seen_nxt     = seen_r;
    opc_nxt      = opc_r;
    out_load     = 1'b0;
    out_data_nxt = out_data_r;
    q_pop        = 1'b0;
    t_we         = 1'b0;
    t_waddr      = TW'(q_item.idx);
    t_raddr      = mid[TW-1:0];
    c_we         = 1'b0;
    c_waddr      = cnt_addr_r;
    c_wdata      = cnt_inc;
    c_raddr      = cnt_addr_r;

    unique case (state_r)
      S_CLR: begin
        c_we    = 1'b1;
        c_waddr = clr_r;
        c_wdata = '0;
        clr_nxt = clr_r + DW'(1);
        if (int'(clr_r) == NUM_DESTS - 1) begin
          open_nxt     = 1'b1;
          fin_kind_nxt = KIND_ACK;
          fin_cnt_nxt  = '0;
          state_nxt    = ack_r ? S_FIN : S_IDLE;
        end
      end
      S_IDLE: begin
        c_raddr = DW'(q_item.idx);
        if (q_valid) begin
          q_pop        = 1'b1;
          fin_cnt_nxt  = '0;
          pend_v_nxt   = 1'b0;
          k_nxt        = '0;
          state_nxt    = S_FIN;
          unique case (q_item.cls)
            CLS_LOAD: begin
              t_we         = (int'(q_item.idx) < TABLE_DEPTH);
              fin_kind_nxt = KIND_ACK;
            end
            CLS_RDD: begin
              cnt_ok_nxt = (int'(q_item.idx) < NUM_DESTS);
              state_nxt  = S_CNT;
            end
            CLS_RDO: begin
              fin_kind_nxt = KIND_COUNT;
              fin_cnt_nxt  = (int'(q_item.idx) < OP_KINDS) ? opc_rd : '0;
            end
            CLS_CLR: begin
              for (int i = 0; i < OP_KINDS; i++) opc_nxt[i] = '0;
              seen_nxt  = '0;
              clr_nxt   = '0;
              ack_nxt   = 1'b1;
              state_nxt = S_CLR;
            end
            CLS_QUERY: begin
              if (opc_rd != 32'hFFFF_FFFF) opc_nxt[opc_sel] = opc_rd + 32'd1;
              key_nxt    = q_item.qkey;
              rkey_nxt   = q_item.rkey;
              scan_nxt   = (q_item.op == OP_SCAN);
              strict_nxt = (q_item.op == OP_PRED);
              lo_nxt     = '0;
              len_nxt    = n_act;
              if (q_item.op == OP_INVALID) begin
                fin_kind_nxt = KIND_INVAL;
              end else if (q_item.op == OP_EMPTY) begin
                fin_kind_nxt = KIND_EMPTY;
              end else begin
                fin_kind_nxt = KIND_NOPART;
                state_nxt    = S_SRCH;
              end
            end
            default: fin_kind_nxt = KIND_INVAL;
          endcase
        end
      end
      S_SRCH: begin
        if (len_r != '0) begin
          state_nxt = S_SCMP;
        end else begin
          p_nxt     = (lo_r == '0) ? '0 : lo_r - NW'(1);
          first_nxt = (lo_r != '0);
          seen_nxt  = '0;
          state_nxt = (!scan_r && lo_r == '0) ? S_FIN : S_WRD;
        end
      end
      S_SCMP: begin
        if (below) begin
          lo_nxt  = mid + NW'(1);
          len_nxt = len_r - half - NW'(1);
        end else begin
          len_nxt = half;
        end
        state_nxt = S_SRCH;
      end
      S_WRD: begin
        t_raddr   = p_r[TW-1:0];
        state_nxt = (p_r < n_act) ? S_WCHK : S_FIN;
      end
      S_WCHK: begin
        t_raddr = p_r[TW-1:0];
        c_raddr = DW'(dst_q_r);
        if (!walk_go) begin
          state_nxt = S_FIN;
        end else if (scan_r && comm_i && seen_r[dst_q_r]) begin
          first_nxt = 1'b0;
          p_nxt     = p_r + NW'(1);
          state_nxt = S_WRD;
        end else begin
          seen_nxt[dst_q_r] = 1'b1;
          cnt_addr_nxt      = DW'(dst_q_r);
          cnt_en_nxt        = (int'(dst_q_r) < NUM_DESTS);
          state_nxt         = S_CWR;
        end
      end
      S_CWR: begin
        t_raddr = p_r[TW-1:0];
        if (!push_pend || out_free) begin
          c_we = cnt_en_r;
          if (push_pend) begin
            out_load     = 1'b1;
            out_data_nxt = '{kind: KIND_ROUTED, dest_id: out_data_r.dest_id,
                             count_value: '0, last: 1'b0};
            out_data_nxt.dest_id = pend_d_r;
          end
          if (k_r < 7'(MAX_RESULTS)) begin
            k_nxt      = k_r + 7'd1;
            pend_v_nxt = 1'b1;
            pend_d_nxt = dst_q_r;
          end else begin
            pend_d_nxt = pend_d_r;
          end
          first_nxt = 1'b0;
          p_nxt     = p_r + NW'(1);
          state_nxt = scan_r ? S_WRD : S_FIN;
        end else begin
          pend_d_nxt = pend_d_r;
        end
      end
      S_CNT: begin
        fin_kind_nxt = KIND_COUNT;
        fin_cnt_nxt  = cnt_ok_r ? cnt_q_r : '0;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          if (pend_v_r) begin
            out_data_nxt = '{kind: KIND_ROUTED, dest_id: pend_d_r,
                             count_value: '0, last: 1'b1};
          end else begin
            out_data_nxt = '{kind: fin_kind_r, dest_id: 5'd0,
                             count_value: fin_cnt_r, last: 1'b1};
          end
          pend_v_nxt = 1'b0;
          ack_nxt    = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // each routed result waits one walk step so the final one can carry last

  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      open_r      <= 1'b0;
      ack_r       <= 1'b0;
      clr_r       <= '0;
      pend_v_r    <= 1'b0;
      k_r         <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < OP_KINDS; i++) opc_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      open_r      <= open_nxt;
      ack_r       <= ack_nxt;
      clr_r       <= clr_nxt;
      pend_v_r    <= pend_v_nxt;
      k_r         <= k_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
      opc_r       <= opc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    len_r      <= len_nxt;
    p_r        <= p_nxt;
    first_r    <= first_nxt;
    scan_r     <= scan_nxt;
    strict_r   <= strict_nxt;
    key_r      <= key_nxt;
    rkey_r     <= rkey_nxt;
    pend_d_r   <= pend_d_nxt;
    fin_kind_r <= fin_kind_nxt;
    fin_cnt_r  <= fin_cnt_nxt;
    cnt_addr_r <= cnt_addr_nxt;
    cnt_en_r   <= cnt_en_nxt;
    cnt_ok_r   <= cnt_ok_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      bnd_mem[t_waddr] <= q_item.bound;
      dst_mem[t_waddr] <= q_item.dest;
    end
    bnd_q_r <= bnd_mem[t_raddr];
    dst_q_r <= dst_mem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      cnt_mem[c_waddr] <= c_wdata;
    end
    cnt_q_r <= cnt_mem[c_raddr];
  end

  assign open_o    = open_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= 7'(MAX_RESULTS))
    else $error("result count past cap");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_v_r)
    else $error("pending result left over in idle");

  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> (out_valid_r && out_data_r.last))
    else $error("final result not marked last");

  a_closed_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR && !open_r) |-> !out_load)
    else $error("result during reset sweep");

endmodule

// ===== rtl/range_partition_key_router.sv =====
// range_partition_key_router: top level with configuration registers
//
//   port group | dir | transfer rule
//   in_*       | in  | in_valid && in_ready, payload in_data
//   out_*      | out | out_valid && out_ready, payload out_data
//   cfg_*      | in  | cfg_we high, register cfg_index, value cfg_wdata
//
// back end: load, op counter reads and invalid items go from idle to final,
// destination counter reads through a count state, key queries through a
// binary search over the entry memory, then a walk that writes a counter per
// reporting entry and skips repeats in commutative mode; clear counters sweeps
// the destination counter memory; after reset the sweep runs with in_ready low
// a two-entry queue and the result register let input and output stall apart
module range_partition_key_router import rpkr_pkg::*; #(
  parameter int TABLE_DEPTH = 64,
  parameter int NUM_DESTS   = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_wdata
);

  logic       comm_r;
  logic [6:0] entries_r;
  logic       open_w, q_valid, q_pop;
  item_t      q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comm_r    <= 1'b0;
      entries_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_COMM) comm_r <= cfg_wdata[0];
      else entries_r <= cfg_wdata;
    end
  end

  rpkr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .open_i   (open_w),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  rpkr_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .NUM_DESTS   (NUM_DESTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .comm_i    (comm_r),
    .entries_i (entries_r),
    .open_o    (open_w),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== bench/range_partition_key_router_tb.sv =====
// range_partition_key_router_tb: self-checking testbench for the range partition key router
`timescale 1ns / 100ps

module range_partition_key_router_tb;
  import rpkr_pkg::*;

  localparam int DEPTH = 64;
  localparam int DESTS = 32;
  localparam int LIMIT = 1000000;
  localparam int SETTLE = 300;
  localparam int EMPTY_ROWS = 15;
  localparam int PHASE_ITEMS = 42;
  localparam logic signed [63:0] KEY_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] KEY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] FIRST_BOUND = 64'shC000_0000_0000_0000;
  localparam logic [2:0] OP_GET = 3'd1;

  typedef struct {
    bit         cfg;
    bit         comm;
    logic [6:0] ents;
    in_t        d;
    bit         typed;
    out_t       exp;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_COMM;
  logic [6:0] cfg_wdata = '0;

  logic signed [63:0] bound_mem[DEPTH];
  logic [4:0] dest_mem[DEPTH];
  logic [31:0] dest_hits[DESTS];
  logic [31:0] op_hits[OP_KINDS];
  bit comm_mode = 1'b0;
  logic [6:0] entry_count = '0;

  out_t pending_results[$];
  row_t rows[$];
  int cycles = 0;
  int errors = 0;
  int transfers_in = 0;
  int transfers_out = 0;

  range_partition_key_router uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit idle_now();
    return ((cycles % 5000) >= 1000) && ($urandom_range(0, 99) < 17);
  endfunction

  function automatic void bump(ref logic [31:0] c);
    if (c != 32'hFFFF_FFFF) c = c + 1;
  endfunction

  function automatic int entries_below(int n, logic signed [63:0] key, bit strict);
    int lo;
    int len;
    int half;
    bit below;
    lo = 0;
    len = n;
    while (len > 0) begin
      half = len / 2;
      below = strict ? (bound_mem[lo + half] < key) : (bound_mem[lo + half] <= key);
      if (below) begin
        lo = lo + half + 1;
        len = len - half - 1;
      end else begin
        len = half;
      end
    end
    return lo;
  endfunction

  function automatic out_t res(logic [2:0] kind, logic [4:0] dst, logic [31:0] cnt);
    return '{kind: kind, dest_id: dst, count_value: cnt, last: 1'b0};
  endfunction

  function automatic void route_query(in_t d, ref out_t r[$]);
    int n;
    int nxt;
    int p;
    bit seen[DESTS];
    n = (entry_count > DEPTH) ? DEPTH : int'(entry_count);
    bump(op_hits[d.op_type]);
    if (d.op_type == OP_INVALID) begin
      r.push_back(res(KIND_INVAL, 0, 0));
      return;
    end
    if (d.op_type == OP_EMPTY) begin
      r.push_back(res(KIND_EMPTY, 0, 0));
      return;
    end
    nxt = entries_below(n, d.query_key, d.op_type == OP_PRED);
    if (d.op_type != OP_SCAN) begin
      if (nxt == 0) begin
        r.push_back(res(KIND_NOPART, 0, 0));
      end else begin
        bump(dest_hits[dest_mem[nxt - 1]]);
        r.push_back(res(KIND_ROUTED, dest_mem[nxt - 1], 0));
      end
      return;
    end
    if (nxt != 0) begin
      p = nxt - 1;
    end else if (n > 0 && bound_mem[0] <= d.right_key) begin
      p = 0;
    end else begin
      r.push_back(res(KIND_NOPART, 0, 0));
      return;
    end
    foreach (seen[i]) seen[i] = 1'b0;
    do begin
      if (!comm_mode || !seen[dest_mem[p]]) begin
        seen[dest_mem[p]] = 1'b1;
        bump(dest_hits[dest_mem[p]]);
        if (r.size() < MAX_RESULTS) r.push_back(res(KIND_ROUTED, dest_mem[p], 0));
      end
      p++;
    end while (p < n && bound_mem[p] <= d.right_key);
  endfunction

  function automatic void predict_routing(in_t d, ref out_t r[$]);
    case (d.cmd)
      CMD_LOAD: begin
        bound_mem[d.entry_index] = d.bound_key;
        dest_mem[d.entry_index] = d.entry_dest;
        r.push_back(res(KIND_ACK, 0, 0));
      end
      CMD_QUERY: route_query(d, r);
      CMD_RDD: r.push_back(res(KIND_COUNT, 0, (d.entry_index < DESTS) ?
                                dest_hits[d.entry_index] : 32'd0));
      CMD_RDO: r.push_back(res(KIND_COUNT, 0, (d.entry_index < OP_KINDS) ?
                                op_hits[d.entry_index] : 32'd0));
      CMD_CLR: begin
        foreach (dest_hits[i]) dest_hits[i] = '0;
        foreach (op_hits[i]) op_hits[i] = '0;
        r.push_back(res(KIND_ACK, 0, 0));
      end
      default: r.push_back(res(KIND_INVAL, 0, 0));
    endcase
    r[r.size() - 1].last = 1'b1;
  endfunction

  task automatic send(in_t d, bit typed = 1'b0, out_t exp = '0);
    out_t r[$];
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
    transfers_in++;
    predict_routing(d, r);
    if (typed) r = '{exp};
    foreach (r[i]) pending_results.push_back(r[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_config(bit cm, logic [6:0] ents);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_COMM;
    cfg_wdata <= {6'd0, cm};
    @(posedge clk);
    cfg_index <= CFG_ENTRIES;
    cfg_wdata <= ents;
    @(posedge clk);
    cfg_we <= 1'b0;
    comm_mode = cm;
    entry_count = ents;
  endtask

  function automatic in_t item(logic [2:0] cmd, logic [5:0] idx, logic signed [63:0] bk,
                               logic [4:0] ed, logic [2:0] op, logic signed [63:0] qk,
                               logic signed [63:0] rk);
    return '{cmd: cmd, entry_index: idx, bound_key: bk, entry_dest: ed, op_type: op,
             query_key: qk, right_key: rk};
  endfunction

  function automatic void add_row(in_t d, bit typed = 1'b0, logic [2:0] kind = KIND_ACK,
                                  logic [31:0] cnt = 0, bit cfg = 1'b0, bit cm = 1'b0,
                                  logic [6:0] ents = 0);
    rows.push_back('{cfg: cfg, comm: cm, ents: ents, d: d, typed: typed,
                     exp: '{kind: kind, dest_id: 5'd0, count_value: cnt, last: 1'b1}});
  endfunction

  function automatic logic signed [63:0] random_key(int n);
    int pick;
    int e;
    pick = $urandom_range(0, 99);
    e = $urandom_range(0, (n > 0) ? n - 1 : DEPTH - 1);
    if (pick < 40) return bound_mem[e] + $signed(64'($urandom_range(0, 2)) - 64'd1);
    if (pick < 45) return KEY_MIN;
    if (pick < 50) return KEY_MAX;
    return {$urandom, $urandom};
  endfunction

  function automatic in_t random_item();
    in_t d;
    int n;
    int pick;
    n = (entry_count > DEPTH) ? DEPTH : int'(entry_count);
    d = item(3'($urandom), 6'($urandom), {$urandom, $urandom}, 5'($urandom),
             3'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      d.cmd = CMD_QUERY;
      if ($urandom_range(0, 99) < 85) d.op_type = 3'($urandom_range(1, 6));
      d.query_key = random_key(n);
      if ($urandom_range(0, 99) < 60) begin
        d.right_key = bound_mem[$urandom_range(0, DEPTH - 1)];
      end else begin
        d.right_key = random_key(n);
      end
    end else if (pick < 78) begin
      d.cmd = CMD_LOAD;
    end else if (pick < 86) begin
      d.cmd = CMD_RDD;
    end else if (pick < 92) begin
      d.cmd = CMD_RDO;
    end else if (pick < 95) begin
      d.cmd = CMD_CLR;
    end else begin
      d.cmd = 3'($urandom_range(5, 7));
    end
    return d;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= !idle_now();
  end

  always @(posedge clk) begin
    out_t exp;
    if (rst_n && out_valid && out_ready) begin
      transfers_out++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual %p", $time, out_data);
        errors++;
      end else begin
        exp = pending_results.pop_front();
        if (out_data.kind !== exp.kind || out_data.dest_id !== exp.dest_id ||
            out_data.count_value !== exp.count_value || out_data.last !== exp.last) begin
          $display("%0t: mismatch, expected %p, actual %p", $time, exp, out_data);
          errors++;
        end
      end
    end
  end

  initial begin
    in_t d;
    bit phase_comm[5] = '{0, 1, 0, 1, 0};
    logic [6:0] phase_ents[5] = '{7'd64, 7'd64, 7'd127, 7'd9, 7'd1};

    foreach (dest_hits[i]) dest_hits[i] = '0;
    foreach (op_hits[i]) op_hits[i] = '0;
    foreach (bound_mem[i]) bound_mem[i] = '0;
    foreach (dest_mem[i]) dest_mem[i] = '0;

    add_row(item(CMD_RDO, 0, 0, 0, 0, 0, 0), 1, KIND_COUNT, 0);
    add_row(item(CMD_QUERY, 0, 0, 0, OP_EMPTY, 0, 0), 1, KIND_EMPTY);
    add_row(item(CMD_QUERY, 0, 0, 0, OP_INVALID, 0, 0), 1, KIND_INVAL);
    add_row(item(CMD_QUERY, 0, 0, 0, OP_GET, KEY_MAX, 0), 1, KIND_NOPART);
    add_row(item(CMD_QUERY, 0, 0, 0, OP_PRED, KEY_MIN, 0), 1, KIND_NOPART);
    add_row(item(CMD_QUERY, 0, 0, 0, OP_SCAN, KEY_MIN, KEY_MAX), 1, KIND_NOPART);
    add_row(item(CMD_QUERY, 0, 0, 0, 3'd2, 0, 0), 1, KIND_NOPART);
    add_row(item(CMD_QUERY, 0, 0, 0, 3'd5, -1, 0), 1, KIND_NOPART);
    add_row(item(CMD_QUERY, 0, 0, 0, 3'd6, 1, 0), 1, KIND_NOPART);
    add_row(item(3'd5, 0, 0, 0, 0, 0, 0), 1, KIND_INVAL);
    add_row(item(3'd7, 6'd63, KEY_MAX, 5'd31, 3'd7, KEY_MAX, KEY_MAX), 1, KIND_INVAL);
    add_row(item(CMD_RDO, 4, 0, 0, 0, 0, 0));
    add_row(item(CMD_RDD, 63, 0, 0, 0, 0, 0), 1, KIND_COUNT, 0);
    add_row(item(CMD_CLR, 0, 0, 0, 0, 0, 0), 1, KIND_ACK);
    add_row(item(CMD_RDO, 7, 0, 0, 0, 0, 0), 1, KIND_COUNT, 0);
    add_row(item(CMD_QUERY, 0, 0, 0, OP_GET, KEY_MIN, 0), 0, KIND_ACK, 0, 1, 0, 7'd64);
    add_row(item(CMD_QUERY, 0, 0, 0, OP_GET, KEY_MAX, 0));
    add_row(item(CMD_QUERY, 0, 0, 0, OP_PRED, KEY_MAX, 0));
    add_row(item(CMD_QUERY, 0, 0, 0, OP_PRED, FIRST_BOUND, 0));
    add_row(item(CMD_QUERY, 0, 0, 0, OP_GET, FIRST_BOUND, 0));
    add_row(item(CMD_QUERY, 0, 0, 0, OP_SCAN, KEY_MIN, KEY_MAX));
    add_row(item(CMD_QUERY, 0, 0, 0, OP_SCAN, KEY_MIN, KEY_MIN));
    add_row(item(CMD_QUERY, 0, 0, 0, OP_SCAN, KEY_MIN, FIRST_BOUND));
    add_row(item(CMD_QUERY, 0, 0, 0, OP_SCAN, KEY_MIN, KEY_MAX), 0, KIND_ACK, 0, 1, 1,
            7'd64);
    add_row(item(CMD_RDD, 5, 0, 0, 0, 0, 0));
    add_row(item(CMD_RDO, 4, 0, 0, 0, 0, 0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (i == EMPTY_ROWS) begin
        for (int e = 0; e < DEPTH; e++) begin
          d = item(CMD_LOAD, 6'(e), (e == DEPTH - 1) ? KEY_MAX :
                   FIRST_BOUND + (64'(e) << 56), 5'($urandom), 0, 0, 0);
          send(d);
        end
      end
      if (rows[i].cfg) write_config(rows[i].comm, rows[i].ents);
      send(rows[i].d, rows[i].typed, rows[i].exp);
    end

    foreach (phase_ents[p]) begin
      write_config(phase_comm[p], phase_ents[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) send(random_item());
    end

    drain();
    $display("%0d items sent and %0d results checked over %0d table settings",
             transfers_in, transfers_out, 5);
    $display("covered loads, routed and scan queries, counter reads and clears");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== range_partition_key_router.f =====
rtl/rpkr_pkg.sv
rtl/rpkr_front.sv
rtl/rpkr_back.sv
rtl/range_partition_key_router.sv
bench/range_partition_key_router_tb.sv
